FILE: sv/blsd_pkg.sv
// ----------------------------------------------------------------------------
// blsd_pkg
// Shared types, codes, constants and Q8.24 helpers of the banded
// least-squares descale unit.
// ----------------------------------------------------------------------------
package blsd_pkg;

   // default store sizes
   localparam int DEF_MAX_SRC  = 4096;
   localparam int DEF_MAX_DEST = 2048;
   localparam int DEF_MAX_TAPS = 16;
   localparam int DEF_MAX_BAND = 7;

   // half bandwidths
   localparam int BAND_SHORT = 5;
   localparam int BAND_LONG  = 7;
   localparam logic [2:0] BAND_MODE_SHORT = 3'd5;

   // field widths
   localparam int FUNC_W      = 3;
   localparam int INDEX_W     = 12;
   localparam int SLOT_W      = 4;
   localparam int VALUE_W     = 32;
   localparam int WIN_W       = 13;
   localparam int OUT_INDEX_W = 11;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 32;

   // item function codes
   localparam logic [FUNC_W-1:0] FN_WINDOW = 3'd0;
   localparam logic [FUNC_W-1:0] FN_WEIGHT = 3'd1;
   localparam logic [FUNC_W-1:0] FN_LOWER  = 3'd2;
   localparam logic [FUNC_W-1:0] FN_UPPER  = 3'd3;
   localparam logic [FUNC_W-1:0] FN_INVDG  = 3'd4;
   localparam logic [FUNC_W-1:0] FN_SAMPLE = 3'd5;
   localparam logic [FUNC_W-1:0] FN_READ   = 3'd6;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_COUNT  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEST_COUNT = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAND_MODE  = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAPS       = 4'd3;

   localparam logic signed [63:0] ACC_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] ACC_MIN    = 64'sh8000_0000_0000_0000;
   localparam logic signed [63:0] ROUND_HALF = 64'sh0000_0000_0080_0000;
   localparam logic signed [39:0] Q_MAX      = 40'sh00_7FFF_FFFF;
   localparam logic signed [39:0] Q_MIN      = 40'shFF_8000_0000;

   typedef enum logic [2:0] {
      AC_HOLD, AC_CLR, AC_ADD, AC_SUB, AC_LDP, AC_LDD
   } acc_op_type;

   typedef enum logic [1:0] {
      OP_TAP, OP_LOW, OP_UPP, OP_DIAG
   } op_sel_type;

   typedef enum logic [1:0] {
      DS_FWD, DS_BWD, DS_ROW, DS_REQ
   } dst_sel_type;

   typedef struct packed {
      acc_op_type  acc_op;
      op_sel_type  op_sel;
      dst_sel_type dst_sel;
      logic        mul_en;
      logic        win_ld;
      logic        v_ld;
      logic        dst_wr;
      logic        out_ld;
   } cmd_type;

   typedef struct packed {
      logic tap_in_win;
      logic tap_in_src;
   } status_type;

   typedef enum logic [20:0] {
      S_IDLE     = 21'h000001,
      S_FW_ROW   = 21'h000002,
      S_FW_WIN   = 21'h000004,
      S_TAP_CHK  = 21'h000008,
      S_TAP_MUL  = 21'h000010,
      S_TAP_ACC  = 21'h000020,
      S_LOW_RD   = 21'h000040,
      S_LOW_MUL  = 21'h000080,
      S_LOW_ACC  = 21'h000100,
      S_RND      = 21'h000200,
      S_DIAG_MUL = 21'h000400,
      S_DIAG_ACC = 21'h000800,
      S_FW_WR    = 21'h001000,
      S_BW_ROW   = 21'h002000,
      S_BW_LD    = 21'h004000,
      S_UP_RD    = 21'h008000,
      S_UP_MUL   = 21'h010000,
      S_UP_ACC   = 21'h020000,
      S_BW_WR    = 21'h040000,
      S_RD_ADDR  = 21'h080000,
      S_RD_OUT   = 21'h100000
   } state_type;

   // saturating 64-bit add
   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? ACC_MIN : ACC_MAX;
      end
      return s[63:0];
   endfunction

   // Q16.48 to Q8.24: add half, floor, saturate
   function automatic logic signed [31:0] round_q24(input logic signed [63:0] acc);
      logic signed [63:0] x;
      logic signed [39:0] q;
      x = sat_add(acc, ROUND_HALF);
      q = x[63:24];
      if (q > Q_MAX) begin
         return 32'sh7FFF_FFFF;
      end
      if (q < Q_MIN) begin
         return 32'sh8000_0000;
      end
      return q[31:0];
   endfunction

endpackage

FILE: sv/blsd_if.sv
// ----------------------------------------------------------------------------
// blsd channel interfaces
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface blsd_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [blsd_pkg::FUNC_W-1:0]           func;
   logic [blsd_pkg::INDEX_W-1:0]          index;
   logic [blsd_pkg::SLOT_W-1:0]           slot;
   logic signed [blsd_pkg::VALUE_W-1:0]   data_value;
   logic [blsd_pkg::WIN_W-1:0]            window_first;
   logic [blsd_pkg::WIN_W-1:0]            window_end;
   logic                                  last;

   modport source (output valid, func, index, slot, data_value, window_first,
                   window_end, last, input ready);
   modport sink   (input valid, func, index, slot, data_value, window_first,
                   window_end, last, output ready);
endinterface

interface blsd_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [blsd_pkg::OUT_INDEX_W-1:0]      out_index;
   logic signed [blsd_pkg::VALUE_W-1:0]   out_value;

   modport source (output valid, out_index, out_value, input ready);
   modport sink   (input valid, out_index, out_value, output ready);
endinterface

interface blsd_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [blsd_pkg::CSR_INDEX_W-1:0]      index;
   logic [blsd_pkg::CSR_DATA_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/banded_least_squares_descale_unit.sv
// ----------------------------------------------------------------------------
// banded_least_squares_descale_unit
// Banded least-squares inverse resampler for one row, Q8.24 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one beat per table entry, sample or read. Window, weight,
//   factor, inverse diagonal and sample beats are stored and accepted one per
//   cycle while the unit is idle. A sample beat with last set starts the row
//   solve; req_ch.ready stays low until the solve is done. The forward and
//   backward passes of each destination row run entirely in the single
//   shared 32x32 multiplier and its accumulator.
//   A read beat returns one rsp_ch beat holding the solved value; the read
//   passes through the S_RD_ADDR and S_RD_OUT states before the response
//   register is loaded, and req_ch.ready stays low until it is, so the next
//   beat waits for the read to finish. A stalled response holds its register
//   and the unit keeps taking load beats; a further read waits for it.
//   csr_ch is always ready; write registers only while the unit is idle.
//   Reset clears the controller and loads the register defaults; the stores
//   are not cleared and hold no defined data until written.
// ----------------------------------------------------------------------------
module banded_least_squares_descale_unit #(
   parameter int MAX_SRC  = blsd_pkg::DEF_MAX_SRC,
   parameter int MAX_DEST = blsd_pkg::DEF_MAX_DEST,
   parameter int MAX_TAPS = blsd_pkg::DEF_MAX_TAPS,
   parameter int MAX_BAND = blsd_pkg::DEF_MAX_BAND
) (
   input  logic        clock,
   input  logic        reset,
   blsd_req_if.sink    req_ch,
   blsd_rsp_if.source  rsp_ch,
   blsd_csr_if.sink    csr_ch
);

   localparam int SW = $clog2(MAX_SRC + 1);
   localparam int DW = $clog2(MAX_DEST + 1);
   localparam int TW = $clog2(MAX_TAPS + 1);
   localparam int BW = $clog2(MAX_BAND + 1);

   logic [12:0] src_count_ff;
   logic [11:0] dest_count_ff;
   logic [2:0]  band_mode_ff;
   logic [4:0]  taps_ff;
   logic        csr_fire, req_fire, req_ready;

   logic [SW-1:0] ns;
   logic [DW-1:0] n;
   logic [TW-1:0] taps;
   logic [BW-1:0] band;

   blsd_pkg::cmd_type    cmd;
   blsd_pkg::status_type status;
   logic [DW-1:0] row;
   logic [TW-1:0] k;
   logic [BW-1:0] d;

   // register writes
   assign csr_ch.ready = 1'b1;
   assign csr_fire     = csr_ch.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_count_ff  <= 13'd4096;
         dest_count_ff <= 12'd2048;
         band_mode_ff  <= 3'd7;
         taps_ff       <= 5'd16;
      end else if (csr_fire) begin
         unique case (csr_ch.index)
            blsd_pkg::CSR_SRC_COUNT:  src_count_ff  <= csr_ch.data[12:0];
            blsd_pkg::CSR_DEST_COUNT: dest_count_ff <= csr_ch.data[11:0];
            blsd_pkg::CSR_BAND_MODE:  band_mode_ff  <= csr_ch.data[2:0];
            blsd_pkg::CSR_TAPS:       taps_ff       <= csr_ch.data[4:0];
            default: ;
         endcase
      end
   end

   // cap counts at the store sizes and pick the half bandwidth
   always_comb begin
      ns   = (32'(src_count_ff) > 32'(MAX_SRC)) ? SW'(MAX_SRC) : SW'(src_count_ff);
      n    = (32'(dest_count_ff) > 32'(MAX_DEST)) ? DW'(MAX_DEST) : DW'(dest_count_ff);
      taps = (32'(taps_ff) > 32'(MAX_TAPS)) ? TW'(MAX_TAPS) : TW'(taps_ff);
      if (band_mode_ff == blsd_pkg::BAND_MODE_SHORT) begin
         band = (blsd_pkg::BAND_SHORT > MAX_BAND) ? BW'(MAX_BAND) : BW'(blsd_pkg::BAND_SHORT);
      end else begin
         band = (blsd_pkg::BAND_LONG > MAX_BAND) ? BW'(MAX_BAND) : BW'(blsd_pkg::BAND_LONG);
      end
   end

   assign req_ch.ready = req_ready;
   assign req_fire     = req_ch.valid && req_ready;

   blsd_ctrl #(
      .MAX_DEST (MAX_DEST),
      .MAX_TAPS (MAX_TAPS),
      .MAX_BAND (MAX_BAND)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_func  (req_ch.func),
      .req_last  (req_ch.last),
      .req_ready (req_ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .n         (n),
      .taps      (taps),
      .band      (band),
      .status    (status),
      .cmd       (cmd),
      .row       (row),
      .k         (k),
      .d         (d)
   );

   blsd_dpath #(
      .MAX_SRC  (MAX_SRC),
      .MAX_DEST (MAX_DEST),
      .MAX_TAPS (MAX_TAPS),
      .MAX_BAND (MAX_BAND)
   ) u_dpath (
      .clock     (clock),
      .req_fire  (req_fire),
      .req_func  (req_ch.func),
      .req_index (req_ch.index),
      .req_slot  (req_ch.slot),
      .req_value (req_ch.data_value),
      .req_first (req_ch.window_first),
      .req_end   (req_ch.window_end),
      .ns        (ns),
      .n         (n),
      .cmd       (cmd),
      .row       (row),
      .k         (k),
      .d         (d),
      .status    (status),
      .rsp_index (rsp_ch.out_index),
      .rsp_value (rsp_ch.out_value)
   );

endmodule

FILE: sv/blsd_dpath.sv
// ----------------------------------------------------------------------------
// blsd_dpath
// Table and sample memories, multiply-accumulate with saturation, rounding
// and the response register.
// ----------------------------------------------------------------------------
module blsd_dpath #(
   parameter int MAX_SRC  = blsd_pkg::DEF_MAX_SRC,
   parameter int MAX_DEST = blsd_pkg::DEF_MAX_DEST,
   parameter int MAX_TAPS = blsd_pkg::DEF_MAX_TAPS,
   parameter int MAX_BAND = blsd_pkg::DEF_MAX_BAND,
   localparam int SW = $clog2(MAX_SRC + 1),
   localparam int DW = $clog2(MAX_DEST + 1),
   localparam int TW = $clog2(MAX_TAPS + 1),
   localparam int BW = $clog2(MAX_BAND + 1)
) (
   input  logic                                  clock,
   input  logic                                  req_fire,
   input  logic [blsd_pkg::FUNC_W-1:0]           req_func,
   input  logic [blsd_pkg::INDEX_W-1:0]          req_index,
   input  logic [blsd_pkg::SLOT_W-1:0]           req_slot,
   input  logic signed [blsd_pkg::VALUE_W-1:0]   req_value,
   input  logic [blsd_pkg::WIN_W-1:0]            req_first,
   input  logic [blsd_pkg::WIN_W-1:0]            req_end,
   input  logic [SW-1:0]                         ns,
   input  logic [DW-1:0]                         n,
   input  blsd_pkg::cmd_type                     cmd,
   input  logic [DW-1:0]                         row,
   input  logic [TW-1:0]                         k,
   input  logic [BW-1:0]                         d,
   output blsd_pkg::status_type                  status,
   output logic [blsd_pkg::OUT_INDEX_W-1:0]      rsp_index,
   output logic signed [blsd_pkg::VALUE_W-1:0]   rsp_value
);

   localparam int SA = (MAX_SRC > 1) ? $clog2(MAX_SRC) : 1;
   localparam int DA = (MAX_DEST > 1) ? $clog2(MAX_DEST) : 1;
   localparam int WA = $clog2(MAX_DEST * MAX_TAPS);
   localparam int FA = $clog2(MAX_BAND * MAX_DEST);

   logic signed [31:0] src_mem [MAX_SRC];
   logic signed [31:0] dst_mem [MAX_DEST];
   logic [blsd_pkg::WIN_W-1:0] wst_mem [MAX_DEST];
   logic [blsd_pkg::WIN_W-1:0] wsp_mem [MAX_DEST];
   logic signed [31:0] inv_mem [MAX_DEST];
   logic signed [31:0] wgt_mem [MAX_DEST * MAX_TAPS];
   logic signed [31:0] low_mem [MAX_BAND * MAX_DEST];
   logic signed [31:0] upp_mem [MAX_BAND * MAX_DEST];

   logic signed [31:0] src_rd_ff, dst_rd_ff, inv_rd_ff, wgt_rd_ff, low_rd_ff, upp_rd_ff;
   logic [blsd_pkg::WIN_W-1:0] wst_rd_ff, wsp_rd_ff;
   logic [blsd_pkg::WIN_W-1:0] start_ff, stop_ff;
   logic signed [31:0] inv_ff, v_ff;
   logic signed [63:0] prod_ff, acc_ff;
   logic [blsd_pkg::INDEX_W-1:0] rq_ff;
   logic [blsd_pkg::OUT_INDEX_W-1:0] rsp_index_ff;
   logic signed [31:0] rsp_value_ff;

   logic        dest_ok, src_ok;
   logic        wgt_we, low_we, upp_we, tab_we, inv_we, src_we;
   logic [31:0] wgt_wa32, fac_wa32, wgt_ra32, fac_ra32, dst_ra32;
   logic [15:0] s_sum;
   logic [DA-1:0] dst_ra, row_a;
   logic signed [31:0] op_a, op_b, rnd;

   // decode table and sample writes
   assign dest_ok  = 32'(req_index) < 32'(MAX_DEST);
   assign src_ok   = 32'(req_index) < 32'(MAX_SRC);
   assign tab_we   = req_fire && req_func == blsd_pkg::FN_WINDOW && dest_ok;
   assign inv_we   = req_fire && req_func == blsd_pkg::FN_INVDG && dest_ok;
   assign src_we   = req_fire && req_func == blsd_pkg::FN_SAMPLE && src_ok;
   assign wgt_we   = req_fire && req_func == blsd_pkg::FN_WEIGHT && dest_ok
                     && 32'(req_slot) < 32'(MAX_TAPS);
   assign low_we   = req_fire && req_func == blsd_pkg::FN_LOWER && dest_ok
                     && 32'(req_slot) < 32'(MAX_BAND);
   assign upp_we   = req_fire && req_func == blsd_pkg::FN_UPPER && dest_ok
                     && 32'(req_slot) < 32'(MAX_BAND);
   assign wgt_wa32 = 32'(req_index) * 32'(MAX_TAPS) + 32'(req_slot);
   assign fac_wa32 = 32'(req_slot) * 32'(MAX_DEST) + 32'(req_index);

   // solve addresses
   assign row_a    = row[DA-1:0];
   assign s_sum    = 16'(start_ff) + 16'(k);
   assign wgt_ra32 = 32'(row) * 32'(MAX_TAPS) + 32'(k);
   assign fac_ra32 = (32'(d) - 32'd1) * 32'(MAX_DEST) + 32'(row);

   always_comb begin
      unique case (cmd.dst_sel)
         blsd_pkg::DS_FWD: dst_ra32 = 32'(row) - 32'(d);
         blsd_pkg::DS_BWD: dst_ra32 = 32'(row) + 32'(d);
         blsd_pkg::DS_ROW: dst_ra32 = 32'(row);
         blsd_pkg::DS_REQ: dst_ra32 = 32'(rq_ff);
         default:          dst_ra32 = 32'(row);
      endcase
   end
   assign dst_ra = dst_ra32[DA-1:0];

   assign status.tap_in_win = 32'(s_sum) < 32'(stop_ff);
   assign status.tap_in_src = 32'(s_sum) < 32'(ns);

   // memories: one write, one registered read each
   always_ff @(posedge clock) begin
      if (src_we) begin
         src_mem[req_index[SA-1:0]] <= req_value;
      end
      src_rd_ff <= src_mem[s_sum[SA-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.dst_wr) begin
         dst_mem[row_a] <= rnd;
      end
      dst_rd_ff <= dst_mem[dst_ra];
   end

   always_ff @(posedge clock) begin
      if (tab_we) begin
         wst_mem[req_index[DA-1:0]] <= req_first;
         wsp_mem[req_index[DA-1:0]] <= req_end;
      end
      wst_rd_ff <= wst_mem[row_a];
      wsp_rd_ff <= wsp_mem[row_a];
   end

   always_ff @(posedge clock) begin
      if (inv_we) begin
         inv_mem[req_index[DA-1:0]] <= req_value;
      end
      inv_rd_ff <= inv_mem[row_a];
   end

   always_ff @(posedge clock) begin
      if (wgt_we) begin
         wgt_mem[wgt_wa32[WA-1:0]] <= req_value;
      end
      wgt_rd_ff <= wgt_mem[wgt_ra32[WA-1:0]];
   end

   always_ff @(posedge clock) begin
      if (low_we) begin
         low_mem[fac_wa32[FA-1:0]] <= req_value;
      end
      low_rd_ff <= low_mem[fac_ra32[FA-1:0]];
   end

   always_ff @(posedge clock) begin
      if (upp_we) begin
         upp_mem[fac_wa32[FA-1:0]] <= req_value;
      end
      upp_rd_ff <= upp_mem[fac_ra32[FA-1:0]];
   end

   // pick multiplier operands
   always_comb begin
      unique case (cmd.op_sel)
         blsd_pkg::OP_TAP:  begin op_a = wgt_rd_ff; op_b = src_rd_ff; end
         blsd_pkg::OP_LOW:  begin op_a = low_rd_ff; op_b = dst_rd_ff; end
         blsd_pkg::OP_UPP:  begin op_a = upp_rd_ff; op_b = dst_rd_ff; end
         blsd_pkg::OP_DIAG: begin op_a = v_ff;      op_b = inv_ff;    end
         default:           begin op_a = v_ff;      op_b = inv_ff;    end
      endcase
   end

   assign rnd = blsd_pkg::round_q24(acc_ff);

   // multiply, accumulate, latch row data
   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= 64'(op_a) * 64'(op_b);
      end
      if (cmd.win_ld) begin
         start_ff <= wst_rd_ff;
         stop_ff  <= wsp_rd_ff;
         inv_ff   <= inv_rd_ff;
      end
      if (cmd.v_ld) begin
         v_ff <= rnd;
      end
      unique case (cmd.acc_op)
         blsd_pkg::AC_HOLD: acc_ff <= acc_ff;
         blsd_pkg::AC_CLR:  acc_ff <= '0;
         blsd_pkg::AC_ADD:  acc_ff <= blsd_pkg::sat_add(acc_ff, prod_ff);
         blsd_pkg::AC_SUB:  acc_ff <= blsd_pkg::sat_add(acc_ff, -prod_ff);
         blsd_pkg::AC_LDP:  acc_ff <= prod_ff;
         blsd_pkg::AC_LDD:  acc_ff <= {{8{dst_rd_ff[31]}}, dst_rd_ff, 24'd0};
         default:           acc_ff <= acc_ff;
      endcase
   end

   // hold the read index, load the response beat
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rq_ff <= req_index;
      end
      if (cmd.out_ld) begin
         rsp_index_ff <= rq_ff[blsd_pkg::OUT_INDEX_W-1:0];
         rsp_value_ff <= (32'(rq_ff) < 32'(n)) ? dst_rd_ff : 32'sd0;
      end
   end

   assign rsp_index = rsp_index_ff;
   assign rsp_value = rsp_value_ff;

endmodule

FILE: sv/blsd_ctrl.sv
// ----------------------------------------------------------------------------
// blsd_ctrl
// Sequencer for loads, reads and the forward and backward row solve.
// ----------------------------------------------------------------------------
module blsd_ctrl #(
   parameter int MAX_DEST = blsd_pkg::DEF_MAX_DEST,
   parameter int MAX_TAPS = blsd_pkg::DEF_MAX_TAPS,
   parameter int MAX_BAND = blsd_pkg::DEF_MAX_BAND,
   localparam int DW = $clog2(MAX_DEST + 1),
   localparam int TW = $clog2(MAX_TAPS + 1),
   localparam int BW = $clog2(MAX_BAND + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [blsd_pkg::FUNC_W-1:0]   req_func,
   input  logic                          req_last,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [DW-1:0]                 n,
   input  logic [TW-1:0]                 taps,
   input  logic [BW-1:0]                 band,
   input  blsd_pkg::status_type          status,
   output blsd_pkg::cmd_type             cmd,
   output logic [DW-1:0]                 row,
   output logic [TW-1:0]                 k,
   output logic [BW-1:0]                 d
);

   blsd_pkg::state_type state_ff, state_in;
   logic [DW-1:0] row_ff, row_in;
   logic [TW-1:0] k_ff, k_in;
   logic [BW-1:0] d_ff, d_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          req_fire;

   assign req_ready = state_ff == blsd_pkg::S_IDLE;
   assign req_fire  = req_valid && req_ready;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      k_in     = k_ff;
      d_in     = d_ff;
      cmd      = '{acc_op: blsd_pkg::AC_HOLD, op_sel: blsd_pkg::OP_TAP,
                   dst_sel: blsd_pkg::DS_ROW, default: 1'b0};
      unique case (state_ff)
         blsd_pkg::S_IDLE: begin
            if (req_fire && req_func == blsd_pkg::FN_SAMPLE && req_last && n != '0) begin
               row_in   = '0;
               state_in = blsd_pkg::S_FW_ROW;
            end else if (req_fire && req_func == blsd_pkg::FN_READ) begin
               state_in = blsd_pkg::S_RD_ADDR;
            end
         end
         blsd_pkg::S_FW_ROW: begin
            cmd.acc_op = blsd_pkg::AC_CLR;
            k_in       = '0;
            state_in   = blsd_pkg::S_FW_WIN;
         end
         blsd_pkg::S_FW_WIN: begin
            cmd.win_ld = 1'b1;
            state_in   = blsd_pkg::S_TAP_CHK;
         end
         blsd_pkg::S_TAP_CHK: begin
            if (k_ff == taps || !status.tap_in_win) begin
               d_in = (32'(row_ff) < 32'(band)) ? BW'(row_ff) : band;
               state_in = (row_ff == '0) ? blsd_pkg::S_RND : blsd_pkg::S_LOW_RD;
            end else if (status.tap_in_src) begin
               state_in = blsd_pkg::S_TAP_MUL;
            end else begin
               k_in = k_ff + TW'(1);
            end
         end
         blsd_pkg::S_TAP_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = blsd_pkg::S_TAP_ACC;
         end
         blsd_pkg::S_TAP_ACC: begin
            cmd.acc_op = blsd_pkg::AC_ADD;
            k_in       = k_ff + TW'(1);
            state_in   = blsd_pkg::S_TAP_CHK;
         end
         blsd_pkg::S_LOW_RD: begin
            cmd.dst_sel = blsd_pkg::DS_FWD;
            state_in    = blsd_pkg::S_LOW_MUL;
         end
         blsd_pkg::S_LOW_MUL: begin
            cmd.op_sel = blsd_pkg::OP_LOW;
            cmd.mul_en = 1'b1;
            state_in   = blsd_pkg::S_LOW_ACC;
         end
         blsd_pkg::S_LOW_ACC: begin
            cmd.acc_op = blsd_pkg::AC_SUB;
            d_in       = d_ff - BW'(1);
            state_in   = (d_ff == BW'(1)) ? blsd_pkg::S_RND : blsd_pkg::S_LOW_RD;
         end
         blsd_pkg::S_RND: begin
            cmd.v_ld = 1'b1;
            state_in = blsd_pkg::S_DIAG_MUL;
         end
         blsd_pkg::S_DIAG_MUL: begin
            cmd.op_sel = blsd_pkg::OP_DIAG;
            cmd.mul_en = 1'b1;
            state_in   = blsd_pkg::S_DIAG_ACC;
         end
         blsd_pkg::S_DIAG_ACC: begin
            cmd.acc_op = blsd_pkg::AC_LDP;
            state_in   = blsd_pkg::S_FW_WR;
         end
         blsd_pkg::S_FW_WR: begin
            cmd.dst_wr = 1'b1;
            if (32'(row_ff) + 32'd1 == 32'(n)) begin
               if (32'(n) < 32'd2) begin
                  state_in = blsd_pkg::S_IDLE;
               end else begin
                  row_in   = n - DW'(2);
                  state_in = blsd_pkg::S_BW_ROW;
               end
            end else begin
               row_in   = row_ff + DW'(1);
               state_in = blsd_pkg::S_FW_ROW;
            end
         end
         blsd_pkg::S_BW_ROW: begin
            state_in = blsd_pkg::S_BW_LD;
         end
         blsd_pkg::S_BW_LD: begin
            cmd.acc_op = blsd_pkg::AC_LDD;
            if (32'(n) - 32'(row_ff) - 32'd1 < 32'(band)) begin
               d_in = BW'(n - row_ff - DW'(1));
            end else begin
               d_in = band;
            end
            state_in = blsd_pkg::S_UP_RD;
         end
         blsd_pkg::S_UP_RD: begin
            cmd.dst_sel = blsd_pkg::DS_BWD;
            state_in    = blsd_pkg::S_UP_MUL;
         end
         blsd_pkg::S_UP_MUL: begin
            cmd.op_sel = blsd_pkg::OP_UPP;
            cmd.mul_en = 1'b1;
            state_in   = blsd_pkg::S_UP_ACC;
         end
         blsd_pkg::S_UP_ACC: begin
            cmd.acc_op = blsd_pkg::AC_SUB;
            d_in       = d_ff - BW'(1);
            state_in   = (d_ff == BW'(1)) ? blsd_pkg::S_BW_WR : blsd_pkg::S_UP_RD;
         end
         blsd_pkg::S_BW_WR: begin
            cmd.dst_wr = 1'b1;
            if (row_ff == '0) begin
               state_in = blsd_pkg::S_IDLE;
            end else begin
               row_in   = row_ff - DW'(1);
               state_in = blsd_pkg::S_BW_ROW;
            end
         end
         blsd_pkg::S_RD_ADDR: begin
            cmd.dst_sel = blsd_pkg::DS_REQ;
            state_in    = blsd_pkg::S_RD_OUT;
         end
         blsd_pkg::S_RD_OUT: begin
            cmd.dst_sel = blsd_pkg::DS_REQ;
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_ld = 1'b1;
               state_in   = blsd_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = blsd_pkg::S_IDLE;
         end
      endcase
   end

   // hold a response beat until taken
   assign rsp_valid_in = cmd.out_ld || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= blsd_pkg::S_IDLE;
         row_ff       <= '0;
         k_ff         <= '0;
         d_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         k_ff         <= k_in;
         d_ff         <= d_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign row       = row_ff;
   assign k         = k_ff;
   assign d         = d_ff;

   // never overwrite a waiting response beat
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_ld |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten while stalled");

   // factor terms always have a nonzero distance
   a_dist_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == blsd_pkg::S_LOW_RD || state_ff == blsd_pkg::S_UP_RD) |-> d_ff != '0)
      else $error("factor term with zero distance");

   // a multiplied tap lies inside the tap count
   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == blsd_pkg::S_TAP_MUL |-> k_ff < taps)
      else $error("tap beyond tap count");

   // solved rows stay below the destination count
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == blsd_pkg::S_FW_ROW || state_ff == blsd_pkg::S_BW_ROW) |-> row_ff < n)
      else $error("row beyond destination count");

endmodule
